// ===== rtl/core/sdtq_pkg.sv =====
package sdtq_pkg;

  // Fixed widths of the item fields.
  localparam int ID_W     = 4;
  localparam int PORT_T_W = 32;
  localparam int FLAG_N   = 2 ** ID_W;

  // Action codes of an input item.
  localparam logic [1:0] ACT_SET    = 2'd0;
  localparam logic [1:0] ACT_CANCEL = 2'd1;
  localparam logic [1:0] ACT_RUN    = 2'd2;

  // Status codes of a result item.
  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_FULL       = 2'd1;
  localparam logic [1:0] STAT_NOT_ACTIVE = 2'd2;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RM_SCAN,
    ST_SET_CHK,
    ST_INS_SCAN,
    ST_INS_TAIL,
    ST_RUN_CHK,
    ST_RUN_LOAD,
    ST_EMIT
  } state_t;

endpackage

// ===== rtl/core/sorted_deadline_timer_queue.sv =====
// Channel  | Handshake               | Payload ports
// ---------+-------------------------+-------------------------------------------------
// input    | start, busy             | in_action, in_timer_id, in_deadline, in_now
// result   | out_valid (1-cycle)     | out_status, out_expired, out_expired_id,
//          |                         | out_next_valid, out_next_deadline,
//          |                         | out_active_count, out_last
//
// Cancel and set scan the queue memory, one entry read per cycle; run pops the expired
// timers one at a time, gives a result for each and then a closing result.
// The queue is a circular buffer, so popping a head costs one memory read.
// Reset is synchronous; the queue memory is not cleared, only the state, count, head pointer, flags and strobe.
// Each result is marked by out_valid for one cycle; the receiver cannot stall it.
module sorted_deadline_timer_queue #(
  parameter int QUEUE_DEPTH   = 16,
  parameter int NUM_TIMER_IDS = 16,
  parameter int TIME_BITS     = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_action,
  input  logic [sdtq_pkg::ID_W-1:0]         in_timer_id,
  input  logic [sdtq_pkg::PORT_T_W-1:0]     in_deadline,
  input  logic [sdtq_pkg::PORT_T_W-1:0]     in_now,
  output logic                              out_valid,
  output logic [1:0]                        out_status,
  output logic                              out_expired,
  output logic [sdtq_pkg::ID_W-1:0]         out_expired_id,
  output logic                              out_next_valid,
  output logic [sdtq_pkg::PORT_T_W-1:0]     out_next_deadline,
  output logic [4:0]                        out_active_count,
  output logic                              out_last
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int TW = TIME_BITS;
  localparam int IW = sdtq_pkg::ID_W;

  // Wraparound-safe ordering: a is before b when a - b is negative.
  function automatic logic is_before(input logic [TW-1:0] a, input logic [TW-1:0] b);
    logic [TW-1:0] diff;
    diff = a - b;
    return diff[TW-1];
  endfunction

  // Next physical slot of the circular buffer.
  function automatic logic [AW-1:0] inc_pa(input logic [AW-1:0] p);
    return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  sdtq_pkg::state_t st_r, st_nxt;

  logic                       op_set_r, op_set_nxt;
  logic [IW-1:0]              id_r, id_nxt;
  logic [TW-1:0]              dl_r, dl_nxt;
  logic [TW-1:0]              now_r, now_nxt;
  logic [CW-1:0]              count_r, count_nxt;
  logic [AW-1:0]              head_pa_r, head_pa_nxt;
  logic [IW-1:0]              head_id_r, head_id_nxt;
  logic [TW-1:0]              head_dl_r, head_dl_nxt;
  logic [sdtq_pkg::FLAG_N-1:0] flags_r, flags_nxt;
  logic [AW-1:0]              ra_r, ra_nxt;
  logic [CW-1:0]              rcnt_r, rcnt_nxt;
  logic                       dv_r, dv_nxt;
  logic                       hit_r, hit_nxt;
  logic [AW-1:0]              hole_r, hole_nxt;
  logic [IW-1:0]              carry_id_r, carry_id_nxt;
  logic [TW-1:0]              carry_dl_r, carry_dl_nxt;
  logic [1:0]                 em_status_r, em_status_nxt;
  logic                       em_exp_r, em_exp_nxt;
  logic [IW-1:0]              em_eid_r, em_eid_nxt;
  logic                       em_last_r, em_last_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [1:0]                 out_status_r, out_status_nxt;
  logic                       out_expired_r, out_expired_nxt;
  logic [IW-1:0]              out_expired_id_r, out_expired_id_nxt;
  logic                       out_next_valid_r, out_next_valid_nxt;
  logic [sdtq_pkg::PORT_T_W-1:0] out_next_deadline_r, out_next_deadline_nxt;
  logic [4:0]                 out_active_count_r, out_active_count_nxt;
  logic                       out_last_r, out_last_nxt;

  // Queue memory and its registered read port.
  logic [IW-1:0]              mem_id [QUEUE_DEPTH];
  logic [TW-1:0]              mem_dl [QUEUE_DEPTH];
  logic [IW-1:0]              rd_id_r;
  logic [TW-1:0]              rd_dl_r;
  logic [AW-1:0]              da_r;
  logic                       mem_re, mem_we;
  logic [AW-1:0]              mem_ra, mem_wa;
  logic [IW-1:0]              mem_wid;
  logic [TW-1:0]              mem_wdl;

  logic accept, id_ok, flag_in, scan_last, pop;

  assign busy      = (st_r != sdtq_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign id_ok     = (32'(in_timer_id) < NUM_TIMER_IDS);
  assign flag_in   = flags_r[in_timer_id];
  assign scan_last = dv_r && (rcnt_r == count_r);
  assign pop       = (count_r != '0) && !is_before(now_r, head_dl_r);

  // Next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      sdtq_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_action)
            sdtq_pkg::ACT_SET: begin
              if (!id_ok) st_nxt = sdtq_pkg::ST_EMIT;
              else if (flag_in) st_nxt = sdtq_pkg::ST_RM_SCAN;
              else st_nxt = sdtq_pkg::ST_SET_CHK;
            end
            sdtq_pkg::ACT_CANCEL: begin
              if (!id_ok || !flag_in) st_nxt = sdtq_pkg::ST_EMIT;
              else st_nxt = sdtq_pkg::ST_RM_SCAN;
            end
            sdtq_pkg::ACT_RUN: st_nxt = sdtq_pkg::ST_RUN_CHK;
            default: st_nxt = sdtq_pkg::ST_EMIT;
          endcase
        end
      end
      sdtq_pkg::ST_RM_SCAN: begin
        if (scan_last) st_nxt = op_set_r ? sdtq_pkg::ST_SET_CHK : sdtq_pkg::ST_EMIT;
      end
      sdtq_pkg::ST_SET_CHK: begin
        if (count_r >= CW'(QUEUE_DEPTH)) st_nxt = sdtq_pkg::ST_EMIT;
        else if (count_r == '0) st_nxt = sdtq_pkg::ST_INS_TAIL;
        else st_nxt = sdtq_pkg::ST_INS_SCAN;
      end
      sdtq_pkg::ST_INS_SCAN: begin
        if (scan_last) st_nxt = sdtq_pkg::ST_INS_TAIL;
      end
      sdtq_pkg::ST_INS_TAIL: st_nxt = sdtq_pkg::ST_EMIT;
      sdtq_pkg::ST_RUN_CHK: begin
        if (pop && (count_r != CW'(1))) st_nxt = sdtq_pkg::ST_RUN_LOAD;
        else st_nxt = sdtq_pkg::ST_EMIT;
      end
      sdtq_pkg::ST_RUN_LOAD: st_nxt = sdtq_pkg::ST_EMIT;
      sdtq_pkg::ST_EMIT: st_nxt = em_last_r ? sdtq_pkg::ST_IDLE : sdtq_pkg::ST_RUN_CHK;
      default: st_nxt = sdtq_pkg::ST_IDLE;
    endcase
  end

  // Datapath, memory control and result fields.
  always_comb begin
    op_set_nxt    = op_set_r;
    id_nxt        = id_r;
    dl_nxt        = dl_r;
    now_nxt       = now_r;
    count_nxt     = count_r;
    head_pa_nxt   = head_pa_r;
    head_id_nxt   = head_id_r;
    head_dl_nxt   = head_dl_r;
    flags_nxt     = flags_r;
    ra_nxt        = ra_r;
    rcnt_nxt      = rcnt_r;
    dv_nxt        = 1'b0;
    hit_nxt       = hit_r;
    hole_nxt      = hole_r;
    carry_id_nxt  = carry_id_r;
    carry_dl_nxt  = carry_dl_r;
    em_status_nxt = em_status_r;
    em_exp_nxt    = em_exp_r;
    em_eid_nxt    = em_eid_r;
    em_last_nxt   = em_last_r;
    mem_re        = 1'b0;
    mem_ra        = ra_r;
    mem_we        = 1'b0;
    mem_wa        = ra_r;
    mem_wid       = id_r;
    mem_wdl       = dl_r;

    out_valid_nxt         = 1'b0;
    out_status_nxt        = out_status_r;
    out_expired_nxt       = out_expired_r;
    out_expired_id_nxt    = out_expired_id_r;
    out_next_valid_nxt    = out_next_valid_r;
    out_next_deadline_nxt = out_next_deadline_r;
    out_active_count_nxt  = out_active_count_r;
    out_last_nxt          = out_last_r;

    case (st_r)
      // Capture the item, decide its status and prime the first scan.
      sdtq_pkg::ST_IDLE: begin
        if (accept) begin
          op_set_nxt    = (in_action == sdtq_pkg::ACT_SET);
          id_nxt        = in_timer_id;
          dl_nxt        = TW'(in_deadline);
          now_nxt       = TW'(in_now);
          em_status_nxt = sdtq_pkg::STAT_OK;
          em_exp_nxt    = 1'b0;
          em_eid_nxt    = '0;
          em_last_nxt   = 1'b1;
          ra_nxt        = head_pa_r;
          rcnt_nxt      = '0;
          hit_nxt       = 1'b0;
          if ((in_action == sdtq_pkg::ACT_SET) && !id_ok) begin
            em_status_nxt = sdtq_pkg::STAT_NOT_ACTIVE;
          end
          if ((in_action == sdtq_pkg::ACT_CANCEL) && (!id_ok || !flag_in)) begin
            em_status_nxt = sdtq_pkg::STAT_NOT_ACTIVE;
          end
          // An active timer that is set or cancelled loses its active flag now; the scan removes its entry.
          if (((in_action == sdtq_pkg::ACT_SET) || (in_action == sdtq_pkg::ACT_CANCEL))
              && id_ok && flag_in) begin
            flags_nxt[in_timer_id] = 1'b0;
          end
        end
      end

      // Find the timer, then move every later entry one slot toward the head.
      sdtq_pkg::ST_RM_SCAN: begin
        mem_re = (rcnt_r < count_r);
        if (mem_re) begin
          ra_nxt   = inc_pa(ra_r);
          rcnt_nxt = rcnt_r + CW'(1);
        end
        dv_nxt = mem_re;
        if (dv_r) begin
          if (hit_r) begin
            mem_we   = 1'b1;
            mem_wa   = hole_r;
            mem_wid  = rd_id_r;
            mem_wdl  = rd_dl_r;
            hole_nxt = da_r;
          end else if (rd_id_r == id_r) begin
            hit_nxt  = 1'b1;
            hole_nxt = da_r;
          end
        end
        if (scan_last) begin
          count_nxt = count_r - CW'(1);
          ra_nxt    = head_pa_r;
          rcnt_nxt  = '0;
          hit_nxt   = 1'b0;
        end
      end

      // Room check after any removal.
      sdtq_pkg::ST_SET_CHK: begin
        if (count_r >= CW'(QUEUE_DEPTH)) em_status_nxt = sdtq_pkg::STAT_FULL;
      end

      // Place the new entry before the first later deadline and ripple the rest up.
      sdtq_pkg::ST_INS_SCAN: begin
        mem_re = (rcnt_r < count_r);
        if (mem_re) begin
          ra_nxt   = inc_pa(ra_r);
          rcnt_nxt = rcnt_r + CW'(1);
        end
        dv_nxt = mem_re;
        if (dv_r) begin
          if (hit_r) begin
            mem_we       = 1'b1;
            mem_wa       = da_r;
            mem_wid      = carry_id_r;
            mem_wdl      = carry_dl_r;
            carry_id_nxt = rd_id_r;
            carry_dl_nxt = rd_dl_r;
          end else if (is_before(dl_r, rd_dl_r)) begin
            mem_we       = 1'b1;
            mem_wa       = da_r;
            carry_id_nxt = rd_id_r;
            carry_dl_nxt = rd_dl_r;
            hit_nxt      = 1'b1;
          end
        end
      end

      // The slot past the old tail takes the displaced entry or the new one.
      sdtq_pkg::ST_INS_TAIL: begin
        mem_we    = 1'b1;
        mem_wa    = ra_r;
        mem_wid   = hit_r ? carry_id_r : id_r;
        mem_wdl   = hit_r ? carry_dl_r : dl_r;
        count_nxt = count_r + CW'(1);
        flags_nxt[id_r] = 1'b1;
      end

      // Pop an expired head and fetch the new one, or close the run.
      sdtq_pkg::ST_RUN_CHK: begin
        if (pop) begin
          count_nxt   = count_r - CW'(1);
          head_pa_nxt = inc_pa(head_pa_r);
          flags_nxt[head_id_r] = 1'b0;
          em_status_nxt = sdtq_pkg::STAT_OK;
          em_exp_nxt    = 1'b1;
          em_eid_nxt    = head_id_r;
          em_last_nxt   = 1'b0;
          if (count_r != CW'(1)) begin
            mem_re = 1'b1;
            mem_ra = inc_pa(head_pa_r);
          end
        end else begin
          em_status_nxt = sdtq_pkg::STAT_OK;
          em_exp_nxt    = 1'b0;
          em_eid_nxt    = '0;
          em_last_nxt   = 1'b1;
        end
      end

      sdtq_pkg::ST_RUN_LOAD: begin
        head_id_nxt = rd_id_r;
        head_dl_nxt = rd_dl_r;
      end

      // Launch one result from the committed queue state.
      sdtq_pkg::ST_EMIT: begin
        out_valid_nxt         = 1'b1;
        out_status_nxt        = em_status_r;
        out_expired_nxt       = em_exp_r;
        out_expired_id_nxt    = em_eid_r;
        out_next_valid_nxt    = (count_r != '0);
        out_next_deadline_nxt = (count_r != '0) ? sdtq_pkg::PORT_T_W'(head_dl_r) : '0;
        out_active_count_nxt  = 5'(count_r);
        out_last_nxt          = em_last_r;
      end

      default: begin
      end
    endcase

    // Keep the head copy in step with writes to the head slot.
    if (mem_we && (mem_wa == head_pa_r)) begin
      head_id_nxt = mem_wid;
      head_dl_nxt = mem_wdl;
    end
  end

  // Queue memory.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_id[mem_wa] <= mem_wid;
      mem_dl[mem_wa] <= mem_wdl;
    end
    if (mem_re) begin
      rd_id_r <= mem_id[mem_ra];
      rd_dl_r <= mem_dl[mem_ra];
      da_r    <= mem_ra;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= sdtq_pkg::ST_IDLE;
      count_r     <= '0;
      head_pa_r   <= '0;
      flags_r     <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      count_r     <= count_nxt;
      head_pa_r   <= head_pa_nxt;
      flags_r     <= flags_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_set_r            <= op_set_nxt;
    id_r                <= id_nxt;
    dl_r                <= dl_nxt;
    now_r               <= now_nxt;
    head_id_r           <= head_id_nxt;
    head_dl_r           <= head_dl_nxt;
    ra_r                <= ra_nxt;
    rcnt_r              <= rcnt_nxt;
    hit_r               <= hit_nxt;
    hole_r              <= hole_nxt;
    carry_id_r          <= carry_id_nxt;
    carry_dl_r          <= carry_dl_nxt;
    em_status_r         <= em_status_nxt;
    em_exp_r            <= em_exp_nxt;
    em_eid_r            <= em_eid_nxt;
    em_last_r           <= em_last_nxt;
    out_status_r        <= out_status_nxt;
    out_expired_r       <= out_expired_nxt;
    out_expired_id_r    <= out_expired_id_nxt;
    out_next_valid_r    <= out_next_valid_nxt;
    out_next_deadline_r <= out_next_deadline_nxt;
    out_active_count_r  <= out_active_count_nxt;
    out_last_r          <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_expired       = out_expired_r;
  assign out_expired_id    = out_expired_id_r;
  assign out_next_valid    = out_next_valid_r;
  assign out_next_deadline = out_next_deadline_r;
  assign out_active_count  = out_active_count_r;
  assign out_last          = out_last_r;

`ifndef SYNTHESIS
  // The queue never holds more entries than it has slots.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("queue count exceeds depth");

  // Between items, the active flags agree with the queue count.
  a_flags_match: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == sdtq_pkg::ST_IDLE) |-> ($countones(flags_r) == 32'(count_r)))
    else $error("active flags disagree with queue count");

  // A scan never writes the slot it is reading in the same cycle.
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (mem_wa != mem_ra))
    else $error("memory read and write collide");

  // Every result strobe comes from the emit step.
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(st_r == sdtq_pkg::ST_EMIT))
    else $error("result strobe without emit step");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int QDEPTH = 16;
  localparam int ID_COUNT = 16;
  localparam int N_ITEMS = 130;
  localparam int DRAIN_CYCLES = 64;
  localparam int MAX_GAP = 19;
  localparam int IDW = sdtq_pkg::ID_W;
  localparam int TW = sdtq_pkg::PORT_T_W;

  // The fourth action code has no meaning; the block answers it with its state.
  localparam logic [1:0] ACT_RESERVED = 2'd3;

  typedef struct packed {
    logic [1:0]    action;
    logic [IDW-1:0] timer_id;
    logic [TW-1:0] deadline;
    logic [TW-1:0] now;
  } timer_cmd_t;

  typedef struct packed {
    logic [1:0]     status;
    logic           expired;
    logic [IDW-1:0] expired_id;
    logic           next_valid;
    logic [TW-1:0]  next_deadline;
    logic [4:0]     active_count;
    logic           last;
  } timer_reply_t;

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_action = '0;
  logic [IDW-1:0] in_timer_id = '0;
  logic [TW-1:0] in_deadline = '0;
  logic [TW-1:0] in_now = '0;
  logic out_valid;
  logic [1:0] out_status;
  logic out_expired;
  logic [IDW-1:0] out_expired_id;
  logic out_next_valid;
  logic [TW-1:0] out_next_deadline;
  logic [4:0] out_active_count;
  logic out_last;

  sorted_deadline_timer_queue #(
    .QUEUE_DEPTH  (QDEPTH),
    .NUM_TIMER_IDS(ID_COUNT),
    .TIME_BITS    (TW)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_timer_id      (in_timer_id),
    .in_deadline      (in_deadline),
    .in_now           (in_now),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_expired      (out_expired),
    .out_expired_id   (out_expired_id),
    .out_next_valid   (out_next_valid),
    .out_next_deadline(out_next_deadline),
    .out_active_count (out_active_count),
    .out_last         (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Commands waiting to be sent, and replies the block still owes.
  timer_cmd_t cmd_backlog[$];
  timer_reply_t awaited_replies[$];
  int issued_cnt = 0;
  int accepted_cnt = 0;
  int total_cmds = 0;
  int fail_count = 0;
  int n_set = 0, n_cancel = 0, n_run = 0, n_reserved = 0;
  int n_replies = 0, n_expired = 0;

  // Shadow copy of the sorted queue and of the per-timer active flags.
  logic [IDW-1:0] sh_id[QDEPTH];
  logic [TW-1:0] sh_dl[QDEPTH];
  int sh_count = 0;
  bit sh_armed[ID_COUNT];

  // Wraparound order: a comes first when a minus b is negative.
  function automatic bit earlier(input logic [TW-1:0] a, input logic [TW-1:0] b);
    logic [TW-1:0] diff;
    diff = a - b;
    return diff[TW-1];
  endfunction

  // Record one reply that shows the queue as it stands now.
  function automatic void push_reply(input logic [1:0] status, input logic expired,
                                     input logic [IDW-1:0] eid, input logic last);
    timer_reply_t r;
    r.status = status;
    r.expired = expired;
    r.expired_id = eid;
    r.next_valid = (sh_count > 0);
    r.next_deadline = (sh_count > 0) ? sh_dl[0] : '0;
    r.active_count = sh_count[4:0];
    r.last = last;
    awaited_replies.push_back(r);
  endfunction

  function automatic void drop_entry(input int pos);
    int j;
    for (j = pos; j + 1 < sh_count; j++) begin
      sh_id[j] = sh_id[j + 1];
      sh_dl[j] = sh_dl[j + 1];
    end
    sh_count--;
  endfunction

  function automatic void remove_timer(input logic [IDW-1:0] id);
    int i;
    for (i = 0; i < sh_count; i++) begin
      if (sh_id[i] == id) begin
        drop_entry(i);
        break;
      end
    end
    sh_armed[id] = 1'b0;
  endfunction

  // A new timer goes behind every entry whose deadline is not later than its own.
  function automatic void insert_timer(input logic [IDW-1:0] id,
                                       input logic [TW-1:0] dl);
    int i, j;
    for (i = 0; i < sh_count; i++) begin
      if (earlier(dl, sh_dl[i])) break;
    end
    for (j = sh_count; j > i; j--) begin
      sh_id[j] = sh_id[j - 1];
      sh_dl[j] = sh_dl[j - 1];
    end
    sh_id[i] = id;
    sh_dl[i] = dl;
    sh_count++;
  endfunction

  // Apply one accepted command to the shadow queue and queue up its replies.
  function automatic void advance_timer_queue(input timer_cmd_t cmd);
    logic [IDW-1:0] hid;
    case (cmd.action)
      sdtq_pkg::ACT_SET: begin
        n_set++;
        if (int'(cmd.timer_id) >= ID_COUNT) begin
          push_reply(sdtq_pkg::STAT_NOT_ACTIVE, 1'b0, '0, 1'b1);
        end else begin
          if (sh_armed[cmd.timer_id]) remove_timer(cmd.timer_id);
          if (sh_count >= QDEPTH) begin
            push_reply(sdtq_pkg::STAT_FULL, 1'b0, '0, 1'b1);
          end else begin
            insert_timer(cmd.timer_id, cmd.deadline);
            sh_armed[cmd.timer_id] = 1'b1;
            push_reply(sdtq_pkg::STAT_OK, 1'b0, '0, 1'b1);
          end
        end
      end
      sdtq_pkg::ACT_CANCEL: begin
        n_cancel++;
        if (int'(cmd.timer_id) >= ID_COUNT || !sh_armed[cmd.timer_id]) begin
          push_reply(sdtq_pkg::STAT_NOT_ACTIVE, 1'b0, '0, 1'b1);
        end else begin
          remove_timer(cmd.timer_id);
          push_reply(sdtq_pkg::STAT_OK, 1'b0, '0, 1'b1);
        end
      end
      sdtq_pkg::ACT_RUN: begin
        n_run++;
        // Pop heads while the current time is not before their deadline.
        while (sh_count > 0 && !earlier(cmd.now, sh_dl[0])) begin
          hid = sh_id[0];
          drop_entry(0);
          sh_armed[hid] = 1'b0;
          push_reply(sdtq_pkg::STAT_OK, 1'b1, hid, 1'b0);
        end
        push_reply(sdtq_pkg::STAT_OK, 1'b0, '0, 1'b1);
      end
      default: begin
        n_reserved++;
        push_reply(sdtq_pkg::STAT_OK, 1'b0, '0, 1'b1);
      end
    endcase
  endfunction

  function automatic bit field_ok(input string name, input logic [TW-1:0] want,
                                  input logic [TW-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void queue_cmd(input logic [1:0] action, input logic [IDW-1:0] id,
                                    input logic [TW-1:0] dl,
                                    input logic [TW-1:0] now);
    timer_cmd_t c;
    c.action = action;
    c.timer_id = id;
    c.deadline = dl;
    c.now = now;
    cmd_backlog.push_back(c);
  endfunction

  // Driver: presents one item at a time on the falling edge, with random gaps
  // between items except in every third stretch of sixteen items.
  int gap_left = 0;
  always @(negedge clk) begin : drive_items
    timer_cmd_t next_cmd;
    bit calm;
    if (rst_n) begin
      calm = ((issued_cnt / 16) % 3) == 1;
      if (start && accepted_cnt != issued_cnt) begin
        // Item still on offer; hold it.
      end else if (gap_left != 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (cmd_backlog.size() != 0) begin
        next_cmd = cmd_backlog.pop_front();
        in_action <= next_cmd.action;
        in_timer_id <= next_cmd.timer_id;
        in_deadline <= next_cmd.deadline;
        in_now <= next_cmd.now;
        start <= 1'b1;
        issued_cnt <= issued_cnt + 1;
        gap_left <= calm ? 0 : $urandom_range(0, MAX_GAP);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check the reply of this cycle first, then take in an accepted item,
  // so a reply that ends one item is never matched against the next one.
  always @(posedge clk) begin : watch_outputs
    timer_reply_t want;
    bit ok;
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        n_replies++;
        if (out_expired === 1'b1) n_expired++;
        if (awaited_replies.size() == 0) begin
          $error("out_valid: expected 0, got 1 with no item awaiting a reply");
          fail_count++;
        end else begin
          want = awaited_replies.pop_front();
          ok = field_ok("out_status", TW'(want.status), TW'(out_status))
             & field_ok("out_expired", TW'(want.expired), TW'(out_expired))
             & field_ok("out_expired_id", TW'(want.expired_id), TW'(out_expired_id))
             & field_ok("out_next_valid", TW'(want.next_valid), TW'(out_next_valid))
             & field_ok("out_next_deadline", want.next_deadline, out_next_deadline)
             & field_ok("out_active_count", TW'(want.active_count),
                        TW'(out_active_count))
             & field_ok("out_last", TW'(want.last), TW'(out_last));
          if (!ok) fail_count++;
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        advance_timer_queue({in_action, in_timer_id, in_deadline, in_now});
        accepted_cnt <= accepted_cnt + 1;
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin : run_test
    logic [TW-1:0] clock_base;
    int pick, step, i;

    // Directed items: empty run, inactive cancel, extreme deadlines, re-set of an
    // active timer, wrap across zero, the reserved action, a full queue with equal
    // deadlines, a set on the full queue and a run that drains every timer.
    queue_cmd(sdtq_pkg::ACT_RUN, 4'd0, $urandom, 32'h0000_0000);
    queue_cmd(sdtq_pkg::ACT_CANCEL, 4'd5, $urandom, $urandom);
    queue_cmd(sdtq_pkg::ACT_SET, 4'd0, 32'h0000_0000, $urandom);
    queue_cmd(sdtq_pkg::ACT_SET, 4'd15, 32'hFFFF_FFFF, $urandom);
    queue_cmd(sdtq_pkg::ACT_SET, 4'd0, 32'h8000_0000, $urandom);
    queue_cmd(sdtq_pkg::ACT_RUN, 4'd9, $urandom, 32'hFFFF_FFFF);
    queue_cmd(sdtq_pkg::ACT_CANCEL, 4'd0, $urandom, $urandom);
    queue_cmd(ACT_RESERVED, 4'd10, $urandom, $urandom);
    for (i = 0; i < ID_COUNT; i++) begin
      queue_cmd(sdtq_pkg::ACT_SET, i[IDW-1:0], 32'h0000_0100 + i / 2, $urandom);
    end
    queue_cmd(sdtq_pkg::ACT_SET, 4'd7, 32'h0000_0100, $urandom);
    queue_cmd(sdtq_pkg::ACT_RUN, 4'd0, $urandom, 32'h0000_0200);

    // Random items: mostly sets near a moving time base and runs that step it
    // forward across the wrap point, with some far-off times and stray commands.
    clock_base = 32'hFFFF_F800;
    while (cmd_backlog.size() < N_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        queue_cmd(sdtq_pkg::ACT_SET, IDW'($urandom_range(0, ID_COUNT - 1)),
                  (pick < 4) ? $urandom : clock_base + $urandom_range(1, 400), $urandom);
      end else if (pick < 65) begin
        queue_cmd(sdtq_pkg::ACT_CANCEL, IDW'($urandom_range(0, ID_COUNT - 1)),
                  $urandom, $urandom);
      end else if (pick < 95) begin
        step = $urandom_range(0, 150);
        if (pick >= 93) begin
          queue_cmd(sdtq_pkg::ACT_RUN, IDW'($urandom), $urandom, $urandom);
        end else begin
          clock_base = clock_base + step;
          queue_cmd(sdtq_pkg::ACT_RUN, IDW'($urandom), $urandom, clock_base);
        end
      end else begin
        queue_cmd(ACT_RESERVED, IDW'($urandom), $urandom, $urandom);
      end
    end
    total_cmds = cmd_backlog.size();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (accepted_cnt < total_cmds) @(posedge clk);
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items: %0d set, %0d cancel, %0d run, %0d reserved.",
             total_cmds, n_set, n_cancel, n_run, n_reserved);
    $display("Checked %0d replies, %0d of them expired timers.", n_replies, n_expired);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin : watchdog
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
